>>> hdl/sha_pkg.sv
// SHA-256 hasher package: payload structs, the controller/datapath command
// struct, round constants, initial hash and a rotate function. No dependencies.
package sha_pkg;

  localparam int BlockBytes = 64;
  localparam int Rounds = 64;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       byte_present;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  typedef struct packed {
    logic       store_byte;    // write byte at fill pointer
    logic       pad_byte;      // write pad byte at pointer (0x80 or zero)
    logic       pad_first;     // pad byte is 0x80
    logic       len_byte;      // write a length byte at pointer
    logic [5:0] ptr;           // block store address
    logic       start_block;   // load window/vars from store and chain
    logic       round;         // perform one round
    logic [5:0] round_idx;
    logic       finish_block;  // add working vars into chain
    logic       clear_msg;     // reset chain, length
    logic       count_byte;    // bit_length += 8
    logic [2:0] out_sel;
  } dp_cmd_t;

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PadMark = 8'h80;

  function automatic logic [31:0] rotr(input logic [31:0] w, input int s);
    rotr = (w >> s) | (w << (32 - s));
  endfunction

endpackage

>>> hdl/sha_datapath.sv
// SHA-256 datapath: block store memory, schedule window, working variables,
// chain value and bit length. Depends on sha_pkg.
module sha_datapath import sha_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  dp_cmd_t     cmd,
  input  logic [7:0]  msg_byte,
  output logic [31:0] digest_word
);

  // block held as 16 big-endian words; byte address = {word, lane}
  logic [31:0] block_store [BlockBytes/4];
  logic [31:0] window [16];
  logic [31:0] wv [8];
  logic [31:0] chain [8];
  logic [63:0] bit_length;
  logic [7:0]  wdata;
  logic [31:0] w15, w2, s0, s1, wt_new, wt, e1, ch, t1, a0, mj;

  always_comb begin
    wdata = msg_byte;
    if (cmd.pad_byte) wdata = cmd.pad_first ? PadMark : 8'h00;
    if (cmd.len_byte) wdata = bit_length[8'(63 - 8 * int'(cmd.ptr[2:0])) -: 8];
  end

  always_ff @(posedge clk) begin
    if (cmd.store_byte || cmd.pad_byte || cmd.len_byte) begin
      case (cmd.ptr[1:0])
        2'd0: block_store[cmd.ptr[5:2]][31:24] <= wdata;
        2'd1: block_store[cmd.ptr[5:2]][23:16] <= wdata;
        2'd2: block_store[cmd.ptr[5:2]][15:8] <= wdata;
        default: block_store[cmd.ptr[5:2]][7:0] <= wdata;
      endcase
    end
  end

  // window[0] always holds W[t]; shifts one place per round
  always_comb begin
    w15 = window[1];
    w2 = window[14];
    s0 = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
    s1 = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
    wt_new = window[0] + s0 + window[9] + s1;
    wt = window[0];
    e1 = rotr(wv[4], 6) ^ rotr(wv[4], 11) ^ rotr(wv[4], 25);
    ch = (wv[4] & wv[5]) ^ (~wv[4] & wv[6]);
    t1 = wv[7] + e1 + ch + RoundK[cmd.round_idx] + wt;
    a0 = rotr(wv[0], 2) ^ rotr(wv[0], 13) ^ rotr(wv[0], 22);
    mj = (wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]);
  end

  always_ff @(posedge clk) begin
    if (cmd.start_block) begin
      for (int i = 0; i < 16; i++) window[i] <= block_store[i];
      for (int i = 0; i < 8; i++) wv[i] <= chain[i];
    end else if (cmd.round) begin
      for (int i = 0; i < 15; i++) window[i] <= window[i+1];
      window[15] <= wt_new;
      wv[7] <= wv[6]; wv[6] <= wv[5]; wv[5] <= wv[4];
      wv[4] <= wv[3] + t1;
      wv[3] <= wv[2]; wv[2] <= wv[1]; wv[1] <= wv[0];
      wv[0] <= t1 + a0 + mj;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_msg) begin
      for (int i = 0; i < 8; i++) chain[i] <= InitHash[i];
      bit_length <= '0;
    end else begin
      if (cmd.finish_block)
        for (int i = 0; i < 8; i++) chain[i] <= chain[i] + wv[i];
      if (cmd.count_byte) bit_length <= bit_length + 64'd8;
    end
  end

  assign digest_word = chain[cmd.out_sel];

endmodule

>>> hdl/sha_controller.sv
// SHA-256 sequencer: input handshake, padding sweep, round counter and
// digest output. Depends on sha_pkg.
module sha_controller import sha_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output logic [2:0] out_idx,
  output dp_cmd_t   cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_START  = 3'd1;
  localparam logic [2:0] S_ROUND  = 3'd2;
  localparam logic [2:0] S_PAD    = 3'd3;
  localparam logic [2:0] S_OUT    = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  logic [2:0] state, state_next;
  logic [5:0] fill, fill_next;
  logic [5:0] rnd, rnd_next;
  logic [2:0] oidx, oidx_next;
  logic       padding, padding_next;  // message end seen, pad sweep pending
  logic       marked, marked_next;    // 0x80 already placed
  logic       accept;
  // this block's pad sweep writes the length: 0x80 went into an earlier block
  // or fits at 55 or below in this one
  logic       lenblk, lenblk_next;

  assign in_ready = (state == S_IDLE);
  assign accept = in_valid && in_ready;
  assign out_valid = (state == S_OUT);
  assign out_idx = oidx;

  always_comb begin
    state_next = state; fill_next = fill; rnd_next = rnd; oidx_next = oidx;
    padding_next = padding; marked_next = marked;
    cmd = '0;
    cmd.ptr = fill;
    cmd.round_idx = rnd;
    cmd.out_sel = oidx;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (in_item.byte_present) begin
            cmd.store_byte = 1'b1;
            cmd.count_byte = 1'b1;
            fill_next = fill + 6'd1;
          end
          padding_next = in_item.end_of_message;
          marked_next = 1'b0;
          if (in_item.byte_present && fill == 6'd63) state_next = S_START;
          else if (in_item.end_of_message) state_next = S_PAD;
        end
      end
      S_PAD: begin
        // one byte per cycle: 0x80, zeros, length in the last eight of the final block
        if (!marked) begin
          cmd.pad_byte = 1'b1; cmd.pad_first = 1'b1; marked_next = 1'b1;
        end else if (fill >= 6'd56 && lenblk) begin
          cmd.len_byte = 1'b1;
        end else begin
          cmd.pad_byte = 1'b1;
        end
        fill_next = fill + 6'd1;
        if (fill == 6'd63) state_next = S_START;
      end
      S_START: begin
        cmd.start_block = 1'b1;
        rnd_next = '0;
        state_next = S_ROUND;
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        rnd_next = rnd + 6'd1;
        if (rnd == 6'd63) state_next = S_FINISH;
      end
      S_FINISH: begin
        // working vars now hold the result of the last round
        cmd.finish_block = 1'b1;
        state_next = S_IDLE;
        if (padding) state_next = lenblk ? S_OUT : S_PAD;
      end
      S_OUT: begin
        if (out_ready) begin
          oidx_next = oidx + 3'd1;
          if (oidx == 3'd7) begin
            cmd.clear_msg = 1'b1;
            padding_next = 1'b0;
            fill_next = '0;
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    lenblk_next = lenblk;
    if (state == S_IDLE) lenblk_next = 1'b0;
    if (state == S_PAD && !marked && fill <= 6'd55) lenblk_next = 1'b1;
    if (state == S_PAD && marked && fill == 6'd0) lenblk_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; fill <= '0; rnd <= '0; oidx <= '0;
      padding <= 1'b0; marked <= 1'b0; lenblk <= 1'b0;
    end else begin
      state <= state_next; fill <= fill_next; rnd <= rnd_next; oidx <= oidx_next;
      padding <= padding_next; marked <= marked_next; lenblk <= lenblk_next;
    end
  end

endmodule

>>> hdl/sha256_message_hasher_unit.sv
// SHA-256 message hasher top level: ties the sequencer to the datapath.
// Depends on sha_pkg, sha_controller, sha_datapath.
//
//  channel | direction | payload     | handshake
//  in      | input     | in_item_t   | in_valid / in_ready
//  out     | output    | out_item_t  | out_valid / out_ready
//
// An ordinary byte is simply stored; after the 64th byte of a block the sequencer
// loads the window and working variables, runs 64 rounds on the single round unit, then does one chain add.
// A final item sweeps the remaining block store one byte per cycle (up to 64),
// compresses, possibly repeats for a second padding block, then presents
// eight digest transactions, one per cycle when out_ready stays high.
// Reset (rst, synchronous) restores the initial hash and zero length.
// out_ready low simply holds the current digest word.
module sha256_message_hasher_unit import sha_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  dp_cmd_t     cmd;
  logic [2:0]  out_idx;
  logic [31:0] digest_word;

  sha_controller u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .in_item,
    .out_valid, .out_ready, .out_idx, .cmd
  );

  sha_datapath u_dp (
    .clk, .rst, .cmd, .msg_byte(in_item.msg_byte), .digest_word
  );

  assign out_item.digest_word = digest_word;
  assign out_item.word_index = out_idx;
  assign out_item.last_word = (out_idx == 3'd7);

  // input is never taken while digest words are being presented
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("input open during digest output");
  // word index advances only on an output transaction
  a_idx_step: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_item.word_index == $past(out_item.word_index)))
    else $error("digest word index moved while stalled");

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// Testbench for sha256_message_hasher_unit: byte messages in, SHA-256 digest words out.
// Depends on sha_pkg and the hasher RTL; a local SHA-256 model predicts each digest.
module tb;
  import sha_pkg::*;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_item;

  sha256_message_hasher_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
  );

  localparam int IdleLimit = 20000;
  localparam int LongHold = 400;

  // Message items waiting for the driver, digest words waiting for the DUT.
  in_item_t  msg_items[$];
  out_item_t digest_words_due[$];

  // Hash state of the local model.
  logic [31:0] chain[8];
  logic [7:0]  block_buf[64];
  int          fill;
  logic [63:0] msg_bits;

  int  errors = 0;
  int  idle_cycles;
  bit  stim_done;
  bit  quiet;         // no idling in the last part of the run
  bit  hold_rx;       // long receiver hold-off request
  int  tx_gap;
  int  rx_gap;
  int  hold_count;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [31:0] ror(input logic [31:0] w, input int s);
    return (w >> s) | (w << (32 - s));
  endfunction

  // One compression of block_buf into chain.
  task automatic compress_buf();
    logic [31:0] w[16];
    logic [31:0] v[8];
    logic [31:0] wt, s0, s1, t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {block_buf[4*i], block_buf[4*i+1], block_buf[4*i+2], block_buf[4*i+3]};
    for (int i = 0; i < 8; i++) v[i] = chain[i];
    for (int t = 0; t < 64; t++) begin
      if (t < 16) begin
        wt = w[t];
      end else begin
        s0 = ror(w[(t-15)&15], 7) ^ ror(w[(t-15)&15], 18) ^ (w[(t-15)&15] >> 3);
        s1 = ror(w[(t-2)&15], 17) ^ ror(w[(t-2)&15], 19) ^ (w[(t-2)&15] >> 10);
        wt = w[t&15] + s0 + w[(t-7)&15] + s1;
        w[t&15] = wt;
      end
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[t] + wt;
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
  endtask

  task automatic restart_hash();
    for (int i = 0; i < 8; i++) chain[i] = InitHash[i];
    fill = 0;
    msg_bits = '0;
  endtask

  // Advance the model by one accepted transaction; queue digest words on a final item.
  task automatic absorb_item(input in_item_t it);
    out_item_t w;
    if (it.byte_present) begin
      block_buf[fill] = it.msg_byte;
      fill = (fill + 1) % 64;
      msg_bits += 64'd8;
      if (fill == 0) compress_buf();
    end
    if (it.end_of_message) begin
      block_buf[fill] = PadMark;
      for (int i = fill + 1; i < 64; i++) block_buf[i] = 8'h00;
      if (fill >= 56) begin
        compress_buf();
        for (int i = 0; i < 64; i++) block_buf[i] = 8'h00;
      end
      for (int i = 0; i < 8; i++) block_buf[56+i] = msg_bits[63-8*i -: 8];
      compress_buf();
      for (int i = 0; i < 8; i++) begin
        w.digest_word = chain[i];
        w.word_index = 3'(i);
        w.last_word = (i == 7);
        digest_words_due.push_back(w);
      end
      restart_hash();
    end
  endtask

  // Queue a whole message of n random bytes; the final byte may ride on the end flag.
  task automatic queue_message(input int n, input bit noise);
    in_item_t it;
    bit tail_on_byte;
    tail_on_byte = (n > 0) && $urandom_range(0, 1);
    for (int i = 0; i < n; i++) begin
      if (noise && $urandom_range(0, 7) == 0) begin
        it.msg_byte = 8'($urandom);
        it.byte_present = 1'b0;
        it.end_of_message = 1'b0;
        msg_items.push_back(it);
      end
      it.msg_byte = 8'($urandom);
      it.byte_present = 1'b1;
      it.end_of_message = tail_on_byte && (i == n - 1);
      msg_items.push_back(it);
    end
    if (!tail_on_byte) begin
      it.msg_byte = 8'($urandom);
      it.byte_present = 1'b0;
      it.end_of_message = 1'b1;
      msg_items.push_back(it);
    end
  endtask

  // Driver: holds each transaction until accepted, with random idle gaps between them.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_item <= '0;
      tx_gap <= 0;
    end else if (!in_valid || in_ready) begin
      if (tx_gap > 0) begin
        tx_gap <= tx_gap - 1;
        in_valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        tx_gap <= $urandom_range(0, 10);
        in_valid <= 1'b0;
      end else if (msg_items.size() > 0) begin
        in_item <= msg_items.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Model update on input acceptance.
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) absorb_item(in_item);
  end

  // Receiver ready: random stalls, plus one long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      rx_gap <= 0;
      hold_count <= 0;
    end else if (hold_rx && hold_count < LongHold) begin
      out_ready <= 1'b0;
      hold_count <= hold_count + 1;
    end else if (rx_gap > 0) begin
      rx_gap <= rx_gap - 1;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      rx_gap <= $urandom_range(0, 10);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Monitor: compare each digest transaction with the oldest expected word.
  always @(posedge clk) begin
    out_item_t exp_w;
    if (!rst && out_valid && out_ready) begin
      if (digest_words_due.size() == 0) begin
        $error("unexpected digest transaction: %h", out_item);
        errors++;
      end else begin
        exp_w = digest_words_due.pop_front();
        if (out_item.digest_word !== exp_w.digest_word) begin
          $error("digest_word exp %h got %h", exp_w.digest_word, out_item.digest_word);
          errors++;
        end
        if (out_item.word_index !== exp_w.word_index) begin
          $error("word_index exp %0d got %0d", exp_w.word_index, out_item.word_index);
          errors++;
        end
        if (out_item.last_word !== exp_w.last_word) begin
          $error("last_word exp %0d got %0d", exp_w.last_word, out_item.last_word);
          errors++;
        end
      end
    end
  end

  // Watchdog: cycles with no transaction on either side.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (!stim_done || digest_words_due.size() > 0) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("[sha256_message_hasher_unit] ERROR");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    while (msg_items.size() > 0 || in_valid || digest_words_due.size() > 0) @(posedge clk);
  endtask

  initial begin
    stim_done = 1'b0;
    quiet = 1'b0;
    hold_rx = 1'b0;
    restart_hash();
    rst = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty message, lone byte, ignored empty item, 0x00/0xff bytes,
    // 55/56/63/64 byte lengths (long tail and full-block boundaries).
    msg_items.push_back('{msg_byte: 8'hff, byte_present: 1'b0, end_of_message: 1'b1});
    msg_items.push_back('{msg_byte: 8'hff, byte_present: 1'b0, end_of_message: 1'b0});
    msg_items.push_back('{msg_byte: 8'h00, byte_present: 1'b1, end_of_message: 1'b1});
    msg_items.push_back('{msg_byte: 8'hff, byte_present: 1'b1, end_of_message: 1'b0});
    msg_items.push_back('{msg_byte: 8'h00, byte_present: 1'b0, end_of_message: 1'b1});
    queue_message(55, 1'b0);
    queue_message(56, 1'b0);
    queue_message(63, 1'b0);
    queue_message(64, 1'b0);
    wait_drained();

    // Long receiver hold-off while a stream of short messages backs up the input.
    hold_rx = 1'b1;
    for (int m = 0; m < 6; m++) queue_message($urandom_range(0, 3), 1'b0);
    wait (hold_count >= LongHold);
    hold_rx = 1'b0;
    wait_drained();

    // Random messages: mostly short, some across block boundaries.
    for (int m = 0; m < 6; m++)
      queue_message(($urandom_range(0, 3) == 0) ? $urandom_range(50, 100)
                                                 : $urandom_range(0, 12), 1'b1);
    wait_drained();   // sender pause until all digests have arrived

    quiet = 1'b1;
    for (int m = 0; m < 4; m++) queue_message($urandom_range(0, 20), 1'b1);
    wait_drained();
    stim_done = 1'b1;
    repeat (200) @(posedge clk);

    if (errors == 0 && digest_words_due.size() == 0)
      $display("[sha256_message_hasher_unit] OK");
    else
      $display("[sha256_message_hasher_unit] ERROR");
    $finish;
  end
endmodule

>>> sim.f
hdl/sha_pkg.sv
hdl/sha_datapath.sv
hdl/sha_controller.sv
hdl/sha256_message_hasher_unit.sv
tb/sv/tb.sv
